// ===== design/btsm_pkg.sv =====
package btsm_pkg;

  localparam int NUM_SLOTS_DEF = 64;
  localparam int SLOT_W       = 6;
  localparam int IDX_W        = SLOT_W + 1;
  localparam int PAGE_W       = 52;
  localparam int PID_W        = 14;
  localparam int CNT_W        = 16;
  localparam logic [SLOT_W-1:0] LW_RESET = SLOT_W'(7);

  typedef enum logic [1:0] {
    REQ_BOLT    = 2'd0,
    REQ_UNBOLT  = 2'd1,
    REQ_FLUSH   = 2'd2,
    REQ_COMPACT = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    ST_NEW       = 3'd0,
    ST_ADDED     = 3'd1,
    ST_NO_SPACE  = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_HELD      = 3'd4,
    ST_RELEASED  = 3'd5,
    ST_MOVE      = 3'd6,
    ST_DONE      = 3'd7
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_CDRY,
    S_CRUN,
    S_CWR,
    S_CDONE
  } state_t;

  typedef struct packed {
    logic [PAGE_W-1:0] page;
    logic [PID_W-1:0]  pid;
    logic              space;
    logic [CNT_W-1:0]  cnt;
  } ent_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic cstep;
    logic dry;
    logic move;
    logic done;
  } cmd_t;

  typedef struct packed {
    logic scan_fin;
    logic c_end;
    logic c_move;
    logic out_free;
  } sts_t;

endpackage

// ===== design/bolted_tlb_slot_manager_core.sv =====
// Pinned-slot manager for the top of a translation buffer: one request at a time.
// Bolt, unbolt and flush walk the pinned region one slot per cycle from the top
// through the entry RAM, stalling while the output register holds an untaken result,
// and stop on the first match. Compact makes two walks over the region, a dry one
// over the live bits to find the new watermark and a real one that moves entries,
// one step per cycle with each move waiting for the output register to be free,
// and ends with one compact-done result. A finished result waits in the output
// register while the next request is taken.
module bolted_tlb_slot_manager_core #(
  parameter int NUM_SLOTS = btsm_pkg::NUM_SLOTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_req_type,
  input  logic [btsm_pkg::PAGE_W-1:0]   in_page_address,
  input  logic [btsm_pkg::PID_W-1:0]    in_pid,
  input  logic                          in_addr_space,
  input  logic [btsm_pkg::CNT_W-1:0]    in_amount,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [2:0]                    out_status,
  output logic [btsm_pkg::SLOT_W-1:0]   out_slot,
  output logic [btsm_pkg::SLOT_W-1:0]   out_from_slot,
  output logic [btsm_pkg::SLOT_W-1:0]   out_watermark,
  output logic                          out_last,
  input  logic                          cfg_we,
  input  logic [btsm_pkg::SLOT_W-1:0]   cfg_wdata
);

  btsm_pkg::cmd_t cmd;
  btsm_pkg::sts_t sts;

  btsm_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_req_type(in_req_type),
    .in_ready   (in_ready),
    .sts        (sts),
    .cmd        (cmd)
  );

  btsm_dp #(
    .NUM_SLOTS(NUM_SLOTS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_req_type    (in_req_type),
    .in_page_address(in_page_address),
    .in_pid         (in_pid),
    .in_addr_space  (in_addr_space),
    .in_amount      (in_amount),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_slot       (out_slot),
    .out_from_slot  (out_from_slot),
    .out_watermark  (out_watermark),
    .out_last       (out_last)
  );

  a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while busy");

  a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last == (out_status != 3'(btsm_pkg::ST_MOVE))))
    else $error("last flag disagrees with status");

  a_move_up: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == 3'(btsm_pkg::ST_MOVE)) |-> (out_slot > out_from_slot))
    else $error("move not towards the top");

endmodule

// ===== design/btsm_ram.sv =====
module btsm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== design/btsm_ctrl.sv =====
module btsm_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic [1:0]          in_req_type,
  output logic                in_ready,
  input  btsm_pkg::sts_t      sts,
  output btsm_pkg::cmd_t      cmd
);

  btsm_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= btsm_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      btsm_pkg::S_IDLE: begin
        if (in_valid) begin
          if (btsm_pkg::req_t'(in_req_type) == btsm_pkg::REQ_COMPACT) begin
            state_nxt = btsm_pkg::S_CDRY;
          end else begin
            state_nxt = btsm_pkg::S_SCAN;
          end
        end
      end
      btsm_pkg::S_SCAN: begin
        if (sts.scan_fin) state_nxt = btsm_pkg::S_IDLE;
      end
      btsm_pkg::S_CDRY: begin
        if (sts.c_end) state_nxt = btsm_pkg::S_CRUN;
      end
      btsm_pkg::S_CRUN: begin
        if (sts.c_end) begin
          state_nxt = btsm_pkg::S_CDONE;
        end else if (sts.c_move) begin
          state_nxt = btsm_pkg::S_CWR;
        end
      end
      btsm_pkg::S_CWR: begin
        if (sts.out_free) state_nxt = btsm_pkg::S_CRUN;
      end
      btsm_pkg::S_CDONE: begin
        if (sts.out_free) state_nxt = btsm_pkg::S_IDLE;
      end
      default: state_nxt = btsm_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (state_r == btsm_pkg::S_IDLE);
    cmd       = '0;
    cmd.load  = (state_r == btsm_pkg::S_IDLE) && in_valid;
    cmd.scan  = (state_r == btsm_pkg::S_SCAN);
    cmd.cstep = (state_r == btsm_pkg::S_CDRY) || (state_r == btsm_pkg::S_CRUN);
    cmd.dry   = (state_r == btsm_pkg::S_CDRY);
    cmd.move  = (state_r == btsm_pkg::S_CWR);
    cmd.done  = (state_r == btsm_pkg::S_CDONE);
  end

endmodule

// ===== design/btsm_dp.sv =====
module btsm_dp #(
  parameter int NUM_SLOTS = btsm_pkg::NUM_SLOTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  btsm_pkg::cmd_t                cmd,
  output btsm_pkg::sts_t                sts,
  input  logic [1:0]                    in_req_type,
  input  logic [btsm_pkg::PAGE_W-1:0]   in_page_address,
  input  logic [btsm_pkg::PID_W-1:0]    in_pid,
  input  logic                          in_addr_space,
  input  logic [btsm_pkg::CNT_W-1:0]    in_amount,
  input  logic                          cfg_we,
  input  logic [btsm_pkg::SLOT_W-1:0]   cfg_wdata,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [2:0]                    out_status,
  output logic [btsm_pkg::SLOT_W-1:0]   out_slot,
  output logic [btsm_pkg::SLOT_W-1:0]   out_from_slot,
  output logic [btsm_pkg::SLOT_W-1:0]   out_watermark,
  output logic                          out_last
);

  localparam int AW = $clog2(NUM_SLOTS);
  localparam int SW = btsm_pkg::SLOT_W;
  localparam int IW = btsm_pkg::IDX_W;
  localparam logic [IW-1:0] TOP  = IW'(NUM_SLOTS - 1);
  localparam logic [IW-1:0] SIZE = IW'(NUM_SLOTS);
  localparam logic [SW-1:0] TOP_SLOT = SW'(NUM_SLOTS - 1);

  btsm_pkg::req_t                req_r;
  logic [btsm_pkg::PAGE_W-1:0]   page_r;
  logic [btsm_pkg::PID_W-1:0]    pid_r;
  logic                          space_r;
  logic [btsm_pkg::CNT_W-1:0]    amt_r;

  logic [SW-1:0] mark_r, mark_nxt;
  logic [SW-1:0] lw_r, lw_nxt;
  logic [SW-1:0] fmark_r, fmark_nxt;
  logic [NUM_SLOTS-1:0] live_r, live_nxt;
  logic [IW-1:0] i_r, i_nxt;
  logic [IW-1:0] low_r, low_nxt;
  logic          pv_r, pv_nxt;
  logic [SW-1:0] pidx_r, pidx_nxt;
  logic          hole_v_r, hole_v_nxt;
  logic [SW-1:0] hole_r, hole_nxt;

  logic              out_valid_r, out_valid_nxt;
  btsm_pkg::status_t out_status_r;
  logic [SW-1:0]     out_slot_r, out_from_r, out_wm_r;
  logic              out_last_r;

  logic              emit;
  btsm_pkg::status_t e_status;
  logic [SW-1:0]     e_slot, e_from, e_wm;
  logic              e_last;

  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  btsm_pkg::ent_t    ram_wdata, rd;

  logic              out_free, match;
  logic [IW-1:0]     mark7;
  logic [btsm_pkg::CNT_W:0]   sum;
  logic [btsm_pkg::CNT_W-1:0] sat;
  logic [SW-1:0]     claim;

  btsm_ram #(
    .WIDTH($bits(btsm_pkg::ent_t)),
    .DEPTH(NUM_SLOTS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(rd)
  );

  always_comb begin
    out_free = !out_valid_r || out_ready;
    mark7    = {1'b0, mark_r};
    match    = pv_r && live_r[pidx_r[AW-1:0]] && (rd.page == page_r) && (rd.pid == pid_r) &&
               ((req_r != btsm_pkg::REQ_BOLT) || (rd.space == space_r));
    sum      = {1'b0, rd.cnt} + {1'b0, amt_r};
    sat      = sum[btsm_pkg::CNT_W] ? '1 : sum[btsm_pkg::CNT_W-1:0];

    mark_nxt   = mark_r;
    lw_nxt     = cfg_we ? cfg_wdata : lw_r;
    fmark_nxt  = fmark_r;
    live_nxt   = live_r;
    i_nxt      = i_r;
    low_nxt    = low_r;
    pv_nxt     = pv_r;
    pidx_nxt   = pidx_r;
    hole_v_nxt = hole_v_r;
    hole_nxt   = hole_r;
    claim      = mark_r;

    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = rd;
    ram_re    = 1'b0;
    ram_raddr = '0;

    emit     = 1'b0;
    e_status = btsm_pkg::ST_NEW;
    e_slot   = '0;
    e_from   = '0;
    e_wm     = fmark_r;
    e_last   = 1'b1;
    sts      = '0;
    sts.out_free = out_free;

    if (cmd.load) begin
      i_nxt      = TOP;
      low_nxt    = mark7 + IW'(1);
      pv_nxt     = 1'b0;
      hole_v_nxt = 1'b0;
    end

    if (cmd.scan && out_free) begin
      if (match) begin
        sts.scan_fin = 1'b1;
        emit         = 1'b1;
        e_slot       = pidx_r;
        ram_waddr    = pidx_r[AW-1:0];
        if (req_r == btsm_pkg::REQ_BOLT) begin
          ram_we        = 1'b1;
          ram_wdata.cnt = sat;
          e_status      = btsm_pkg::ST_ADDED;
        end else if ((req_r == btsm_pkg::REQ_UNBOLT) && (rd.cnt > amt_r)) begin
          ram_we        = 1'b1;
          ram_wdata.cnt = rd.cnt - amt_r;
          e_status      = btsm_pkg::ST_HELD;
        end else begin
          live_nxt[pidx_r[AW-1:0]] = 1'b0;
          e_status = btsm_pkg::ST_RELEASED;
        end
      end else if (i_r > mark7) begin
        ram_re    = 1'b1;
        ram_raddr = i_r[AW-1:0];
        pv_nxt    = 1'b1;
        pidx_nxt  = i_r[SW-1:0];
        if (!hole_v_r && !live_r[i_r[AW-1:0]]) begin
          hole_v_nxt = 1'b1;
          hole_nxt   = i_r[SW-1:0];
        end
        i_nxt = i_r - IW'(1);
      end else if (pv_r) begin
        pv_nxt = 1'b0;
      end else begin
        sts.scan_fin = 1'b1;
        emit         = 1'b1;
        if (req_r == btsm_pkg::REQ_BOLT) begin
          if (hole_v_r || (mark_r > lw_r)) begin
            if (hole_v_r) begin
              claim = hole_r;
            end else begin
              claim    = mark_r;
              mark_nxt = mark_r - SW'(1);
            end
            ram_we          = 1'b1;
            ram_waddr       = claim[AW-1:0];
            ram_wdata.page  = page_r;
            ram_wdata.pid   = pid_r;
            ram_wdata.space = space_r;
            ram_wdata.cnt   = amt_r;
            live_nxt[claim[AW-1:0]] = (amt_r != '0);
            e_status = btsm_pkg::ST_NEW;
            e_slot   = claim;
          end else begin
            e_status = btsm_pkg::ST_NO_SPACE;
          end
        end else begin
          e_status = btsm_pkg::ST_NOT_FOUND;
        end
      end
      e_wm = mark_nxt;
    end

    // walk: low climbs past holes, i descends past live entries
    if (cmd.cstep) begin
      if (i_r < low_r) begin
        sts.c_end = 1'b1;
        if (cmd.dry) begin
          fmark_nxt = (low_r == SIZE) ? mark_r : SW'(low_r - IW'(1));
          i_nxt     = TOP;
          low_nxt   = mark7 + IW'(1);
        end
      end else if (!live_r[low_r[AW-1:0]]) begin
        low_nxt = low_r + IW'(1);
      end else if (!live_r[i_r[AW-1:0]] && (i_r > low_r)) begin
        if (cmd.dry) begin
          low_nxt = low_r + IW'(1);
          i_nxt   = i_r - IW'(1);
        end else begin
          sts.c_move = 1'b1;
          ram_re     = 1'b1;
          ram_raddr  = low_r[AW-1:0];
        end
      end else begin
        i_nxt = i_r - IW'(1);
      end
    end

    if (cmd.move && out_free) begin
      ram_we    = 1'b1;
      ram_waddr = i_r[AW-1:0];
      live_nxt[i_r[AW-1:0]]   = 1'b1;
      live_nxt[low_r[AW-1:0]] = 1'b0;
      emit     = 1'b1;
      e_status = btsm_pkg::ST_MOVE;
      e_slot   = i_r[SW-1:0];
      e_from   = low_r[SW-1:0];
      e_last   = 1'b0;
      low_nxt  = low_r + IW'(1);
      i_nxt    = i_r - IW'(1);
    end

    if (cmd.done && out_free) begin
      emit     = 1'b1;
      e_status = btsm_pkg::ST_DONE;
      mark_nxt = fmark_r;
    end

    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mark_r      <= TOP_SLOT;
      lw_r        <= btsm_pkg::LW_RESET;
      live_r      <= '0;
      pv_r        <= 1'b0;
      hole_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      mark_r      <= mark_nxt;
      lw_r        <= lw_nxt;
      live_r      <= live_nxt;
      pv_r        <= pv_nxt;
      hole_v_r    <= hole_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r   <= btsm_pkg::req_t'(in_req_type);
      page_r  <= in_page_address;
      pid_r   <= in_pid;
      space_r <= in_addr_space;
      amt_r   <= in_amount;
    end
    fmark_r  <= fmark_nxt;
    i_r      <= i_nxt;
    low_r    <= low_nxt;
    pidx_r   <= pidx_nxt;
    hole_r   <= hole_nxt;
    if (emit) begin
      out_status_r <= e_status;
      out_slot_r   <= e_slot;
      out_from_r   <= e_from;
      out_wm_r     <= e_wm;
      out_last_r   <= e_last;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_slot      = out_slot_r;
  assign out_from_slot = out_from_r;
  assign out_watermark = out_wm_r;
  assign out_last      = out_last_r;

endmodule
